@@ design/base64_key_decoder_defines.svh @@
// Assertion macros shared by the base64 key decoder RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef BASE64_KEY_DECODER_DEFINES_SVH
`define BASE64_KEY_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define B64KD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("b64kd: assertion failed");
// Check a property on every clock edge, reset included.
`define B64KD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("b64kd: assertion failed");
`else
`define B64KD_ASSERT(lbl, clk, rst, prop)
`define B64KD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ design/b64kd_pkg.sv @@
// Types, codes and the character classifier of the base64 key decoder.
// No dependencies; used by b64kd_fifo, b64kd_core and base64_key_decoder.
`default_nettype none

package b64kd_pkg;

  // Largest key the block will accept; longer lengths saturate to it
  localparam int unsigned MaxKeyBytes = 64;
  localparam logic [7:0]  MaxKeyLen   = 8'(MaxKeyBytes);

  // Final status reported by the end request
  localparam logic [2:0] StNone     = 3'd0;
  localparam logic [2:0] StOk       = 3'd1;
  localparam logic [2:0] StBadChar  = 3'd2;
  localparam logic [2:0] StTooLong  = 3'd3;
  localparam logic [2:0] StTooShort = 3'd4;

  // Sticky stream error
  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrBadChar = 2'd1,
    ErrTooLong = 2'd2
  } err_t;

  // Character class
  typedef enum logic [1:0] {
    ChDigit = 2'd0,
    ChSpace = 2'd1,
    ChPad   = 2'd2,
    ChBad   = 2'd3
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [5:0] digit;
  } char_class_t;

  // One output result
  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       byte_valid;
    logic [2:0] final_status;
    logic       last_of_run;
  } result_t;

  // Up to three results produced by one request
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     item;
  } result_bundle_t;

  // Map an ASCII character to its base64 digit or class
  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.kind  = ChDigit;
    r.digit = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.digit = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.digit = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.digit = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.digit = 6'd62;
    end else if (c == 8'h2F) begin
      r.digit = 6'd63;
    end else if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
      r.kind = ChSpace;
    end else if (c == 8'h3D) begin
      r.kind = ChPad;
    end else begin
      r.kind = ChBad;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/b64kd_fifo.sv @@
// Result queue of the base64 key decoder: takes up to three results a cycle,
// releases one while out_ready is high. Depends on b64kd_pkg and base64_key_decoder_defines.svh.
`default_nettype none
`include "base64_key_decoder_defines.svh"

module b64kd_fifo #(
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  input  b64kd_pkg::result_bundle_t push,
  output logic                     room,
  output logic                     out_valid,
  output b64kd_pkg::result_t       out_item,
  input  wire                      out_ready
);
  import b64kd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] RoomLimit = CW'(DEPTH - 3);
  localparam logic [CW-1:0] Full      = CW'(DEPTH);

  result_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_after_pop;
  logic            pop;

  assign out_valid       = (count != '0);
  assign out_item        = mem[rd_ptr];
  assign pop             = out_valid && out_ready;
  assign count_after_pop = count - CW'(pop);
  // Room for a full burst of three once the current pop is done
  assign room            = (count_after_pop <= RoomLimit);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count_after_pop + CW'(push.count);
    end
  end

  // Store the burst in consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.count) begin
        mem[AW'(wr_ptr + AW'(k))] <= push.item[2-k];
      end
    end
  end

  `B64KD_ASSERT(a_no_overflow, clk, rst, count <= Full)
  `B64KD_ASSERT(a_push_has_room, clk, rst, (push.count != 2'd0) |-> room)
  `B64KD_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> (count == '0))

endmodule

`default_nettype wire

@@ design/b64kd_core.sv @@
// Decoding state and one-request step logic of the base64 key decoder.
// Depends on b64kd_pkg and base64_key_decoder_defines.svh.
`default_nettype none
`include "base64_key_decoder_defines.svh"

module b64kd_core (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire  [6:0]                cfg_wdata,
  input  wire                       go,
  input  wire  [7:0]                char_byte,
  input  wire                       end_of_input,
  output b64kd_pkg::result_bundle_t res
);
  import b64kd_pkg::*;

  // Stream state
  logic [6:0]  key_length;
  logic [23:0] digit_group;
  logic [1:0]  digits_held;
  logic [6:0]  bytes_written;
  err_t        error_code;
  logic        pad_seen;

  logic [23:0] digit_group_next;
  logic [1:0]  digits_held_next;
  logic [6:0]  bytes_written_next;
  err_t        error_code_next;
  logic        pad_seen_next;

  logic [7:0]  eff_len;
  logic [7:0]  room_left;
  char_class_t cls;

  assign eff_len   = ({1'b0, key_length} > MaxKeyLen) ? MaxKeyLen : {1'b0, key_length};
  assign room_left = (eff_len > {1'b0, bytes_written}) ? (eff_len - {1'b0, bytes_written})
                                                       : 8'd0;
  assign cls       = classify(char_byte);

  // Step: update state and build the results of one request
  always_comb begin
    logic [1:0]  nbytes;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [23:0] grp;
    logic [2:0]  status;
    nbytes = 2'd0;
    b0     = '0;
    b1     = '0;
    b2     = '0;
    grp    = {digit_group[17:0], cls.digit};
    status = StNone;
    res    = '0;
    digit_group_next   = digit_group;
    digits_held_next   = digits_held;
    bytes_written_next = bytes_written;
    error_code_next    = error_code;
    pad_seen_next      = pad_seen;

    if (go && end_of_input) begin
      // Flush a partial group, then report
      if (error_code == ErrNone) begin
        if (digits_held == 2'd3) begin
          if (room_left < 8'd2) begin
            error_code_next = ErrTooLong;
          end else begin
            nbytes = 2'd2;
            b0     = digit_group[17:10];
            b1     = digit_group[9:2];
          end
        end else if (digits_held == 2'd2) begin
          if (room_left < 8'd1) begin
            error_code_next = ErrTooLong;
          end else begin
            nbytes = 2'd1;
            b0     = digit_group[11:4];
          end
        end
      end
      if (error_code_next == ErrBadChar) begin
        status = StBadChar;
      end else if (error_code_next == ErrTooLong) begin
        status = StTooLong;
      end else if ({1'b0, 7'(bytes_written + 7'(nbytes))} < eff_len) begin
        status = StTooShort;
      end else begin
        status = StOk;
      end
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < nbytes) begin
          res.item[2-k].data_byte  = (k == 0) ? b0 : b1;
          res.item[2-k].byte_index = 6'(bytes_written[5:0] + 6'(k));
          res.item[2-k].byte_valid = 1'b1;
        end else if (2'(k) == nbytes) begin
          res.item[2-k].final_status = status;
          res.item[2-k].last_of_run  = 1'b1;
        end
      end
      res.count = 2'(nbytes + 2'd1);
      // Return to idle
      digit_group_next   = '0;
      digits_held_next   = 2'd0;
      bytes_written_next = '0;
      error_code_next    = ErrNone;
      pad_seen_next      = 1'b0;
    end else if (go && (error_code == ErrNone) && !pad_seen) begin
      case (cls.kind)
        ChSpace: begin
        end
        ChPad: begin
          pad_seen_next = 1'b1;
        end
        ChBad: begin
          error_code_next = ErrBadChar;
        end
        ChDigit: begin
          digit_group_next = grp;
          if (digits_held != 2'd3) begin
            digits_held_next = 2'(digits_held + 2'd1);
          end else begin
            digits_held_next = 2'd0;
            if (room_left < 8'd3) begin
              error_code_next = ErrTooLong;
            end else begin
              b0 = grp[23:16];
              b1 = grp[15:8];
              b2 = grp[7:0];
              for (int k = 0; k < 3; k++) begin
                res.item[2-k].data_byte  = (k == 0) ? b0 : ((k == 1) ? b1 : b2);
                res.item[2-k].byte_index = 6'(bytes_written[5:0] + 6'(k));
                res.item[2-k].byte_valid = 1'b1;
              end
              res.item[0].last_of_run = 1'b1;
              res.count          = 2'd3;
              bytes_written_next = 7'(bytes_written + 7'd3);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the configured key length
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= 7'd32;
    end else if (cfg_we) begin
      key_length <= cfg_wdata;
    end
  end

  // Advance the stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_group   <= '0;
      digits_held   <= '0;
      bytes_written <= '0;
      error_code    <= ErrNone;
      pad_seen      <= 1'b0;
    end else begin
      digit_group   <= digit_group_next;
      digits_held   <= digits_held_next;
      bytes_written <= bytes_written_next;
      error_code    <= error_code_next;
      pad_seen      <= pad_seen_next;
    end
  end

  `B64KD_ASSERT(a_end_clears, clk, rst, (go && end_of_input) |=> ((digits_held == 2'd0) && (bytes_written == 7'd0) && (error_code == ErrNone) && !pad_seen))
  `B64KD_ASSERT(a_end_reports, clk, rst, (go && end_of_input) |-> ((res.count != 2'd0) && res.item[3 - res.count].last_of_run))
  `B64KD_ASSERT(a_idle_quiet, clk, rst, !go |-> (res.count == 2'd0))
  `B64KD_ASSERT(a_within_key, clk, rst, $past(go) |-> ({1'b0, bytes_written} <= MaxKeyLen))

endmodule

`default_nettype wire

@@ design/base64_key_decoder.sv @@
// Top level of the base64 key decoder: input register, step logic, result queue.
// Depends on b64kd_pkg, b64kd_core and b64kd_fifo.
//
//   Channel  | Direction | Handshake                 | Contents
//   s_axis   | in        | s_axis_tvalid/tready      | one character, tlast = end item
//   m_axis   | out       | m_axis_tvalid/tready      | key byte or final status
//   cfg      | in        | cfg_we                    | key_length
//
// One character is taken per cycle while the result queue has room for a burst
// of three; an accepted character is held in the input register and is decoded
// as it leaves it, and its results pass through the result queue to m_axis.
// The result queue drains one result per cycle with m_axis_tready high; a group
// of four digits gives three bytes, so a character stream keeps its one-per-cycle rate.
// Synchronous reset clears the stream and sets key_length to 32.
// s_axis stalls only while the queue cannot take a burst of three results.
`default_nettype none

module base64_key_decoder #(
  parameter int FIFO_DEPTH = 8
) (
  input  wire         clk,
  input  wire         rst,
  // configuration
  input  wire         cfg_we,
  input  wire  [6:0]  cfg_wdata,     // key_length
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,  // [7:0] char_byte
  input  wire         s_axis_tlast,  // end_of_input
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] data_byte, [13:8] byte_index, [15:14] zero
  output logic [3:0]  m_axis_tuser,  // [0] byte_valid, [3:1] final_status
  output logic        m_axis_tlast   // last_of_run
);
  import b64kd_pkg::*;

  logic           in_valid;
  logic [7:0]     in_char;
  logic           in_end;
  logic           room;
  logic           process;
  logic           s_accept;
  result_bundle_t res;
  result_t        out_item;

  assign process       = in_valid && room;
  assign s_axis_tready = !in_valid || room;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Hold the request until the queue can take its results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_char <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  // Decode one request
  b64kd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .go           (process),
    .char_byte    (in_char),
    .end_of_input (in_end),
    .res          (res)
  );

  // Queue results toward the output
  b64kd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_item  (out_item),
    .out_ready (m_axis_tready)
  );

  // Pack the result fields
  assign m_axis_tdata = {2'b00, out_item.byte_index, out_item.data_byte};
  assign m_axis_tuser = {out_item.final_status, out_item.byte_valid};
  assign m_axis_tlast = out_item.last_of_run;

endmodule

`default_nettype wire
